// ===== sv/mme_pkg.sv =====
`default_nettype none
package mme_pkg;

  // Largest matrix dimension held by the element stores.
  localparam int MAX_DIM = 16;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths of the channels and registers.
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 40;
  localparam int CFG_W   = 5;
  localparam int CFG_A_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_FETCH  = 2'd2
  } mode_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ROWS_M  = 2'd0,
    REG_INNER_N = 2'd1,
    REG_COLS_P  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic             a_we;    // write A store from the input beat
    logic             b_we;    // write B store from the input beat
    logic             start;   // latch fetch indices, clear accumulator
    logic             issue;   // read A[row][k] and B[k][col]
    logic [DIM_W-1:0] k;
    logic             finish;  // load the result register
    logic             err;     // result is an index error
  } mme_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;  // reads or products still in flight
  } mme_sts_t;

endpackage
`default_nettype wire

// ===== sv/mme_if.sv =====
`default_nettype none
interface mme_in_if;
  logic                          valid;
  logic                          ready;
  logic [mme_pkg::MODE_W-1:0]    mode;
  logic [mme_pkg::IDX_W-1:0]     row;
  logic [mme_pkg::IDX_W-1:0]     col;
  logic signed [mme_pkg::VAL_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface mme_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mme_pkg::SUM_W-1:0] sum;
  logic                             index_error;

  modport source (output valid, sum, index_error, input ready);
  modport sink   (input valid, sum, index_error, output ready);
endinterface
`default_nettype wire

// ===== sv/mme_ctrl.sv =====
`default_nettype none
module mme_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [mme_pkg::CFG_A_W-1:0]    cfg_index,
  input  wire [mme_pkg::CFG_W-1:0]      cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [mme_pkg::MODE_W-1:0]     in_mode,
  input  wire [mme_pkg::IDX_W-1:0]      in_row,
  input  wire [mme_pkg::IDX_W-1:0]      in_col,
  output logic                          out_valid,
  input  wire                           out_ready,
  output mme_pkg::mme_cmd_t             cmd,
  input  mme_pkg::mme_sts_t             sts
);

  mme_pkg::state_t state_r, state_nxt;
  logic [mme_pkg::CFG_W-1:0] rows_r, inner_r, cols_r;
  logic [mme_pkg::DIM_W-1:0] k_r, k_nxt;
  logic                      err_r, err_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [mme_pkg::CNT_W-1:0] m_cnt, n_cnt, p_cnt;
  logic [31:0]               row_w, col_w;
  logic                      accept, row_in_m, row_in_n, col_in_n, col_in_p, k_last;

  function automatic logic [mme_pkg::CNT_W-1:0] clamp_dim(input logic [mme_pkg::CFG_W-1:0] v);
    if (32'(v) > 32'(mme_pkg::MAX_DIM)) begin
      return mme_pkg::CNT_W'(mme_pkg::MAX_DIM);
    end
    return mme_pkg::CNT_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mme_pkg::CFG_RESET;
      inner_r <= mme_pkg::CFG_RESET;
      cols_r  <= mme_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::REG_ROWS_M:  rows_r  <= cfg_data;
        mme_pkg::REG_INNER_N: inner_r <= cfg_data;
        mme_pkg::REG_COLS_P:  cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_cnt = clamp_dim(rows_r);
  assign n_cnt = clamp_dim(inner_r);
  assign p_cnt = clamp_dim(cols_r);

  assign row_w    = 32'(in_row);
  assign col_w    = 32'(in_col);
  assign row_in_m = row_w < 32'(m_cnt);
  assign row_in_n = row_w < 32'(n_cnt);
  assign col_in_n = col_w < 32'(n_cnt);
  assign col_in_p = col_w < 32'(p_cnt);
  assign k_last   = (mme_pkg::CNT_W'(k_r) + mme_pkg::CNT_W'(1)) == n_cnt;

  assign in_ready  = (state_r == mme_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.k         = k_r;
    cmd.err       = err_r;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            mme_pkg::MODE_LOAD_A: cmd.a_we = row_in_m && col_in_n;
            mme_pkg::MODE_LOAD_B: cmd.b_we = row_in_n && col_in_p;
            mme_pkg::MODE_FETCH: begin
              cmd.start = 1'b1;
              k_nxt     = '0;
              err_nxt   = !(row_in_m && col_in_p);
              // error or empty product: nothing to walk
              if (!(row_in_m && col_in_p) || n_cnt == '0) begin
                state_nxt = mme_pkg::ST_DRAIN;
              end else begin
                state_nxt = mme_pkg::ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      mme_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
        k_nxt     = k_r + mme_pkg::DIM_W'(1);
        if (k_last) begin
          state_nxt = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (!sts.busy && (!out_valid_r || out_ready)) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mme_pkg::ST_IDLE;
      k_r         <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mme_datapath.sv =====
`default_nettype none
module mme_datapath (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire [mme_pkg::IDX_W-1:0]          in_row,
  input  wire [mme_pkg::IDX_W-1:0]          in_col,
  input  wire signed [mme_pkg::VAL_W-1:0]   in_value,
  output logic signed [mme_pkg::SUM_W-1:0]  out_sum,
  output logic                              out_index_error,
  input  mme_pkg::mme_cmd_t                 cmd,
  output mme_pkg::mme_sts_t                 sts
);

  logic [mme_pkg::VAL_W-1:0] a_mem [mme_pkg::DEPTH];
  logic [mme_pkg::VAL_W-1:0] b_mem [mme_pkg::DEPTH];

  logic [mme_pkg::DIM_W-1:0]         row_r, col_r;
  logic signed [mme_pkg::VAL_W-1:0]  a_q_r, b_q_r;
  logic signed [mme_pkg::PROD_W-1:0] prod_r;
  logic signed [mme_pkg::SUM_W-1:0]  acc_r, sum_r;
  logic                              rd_vld_r, prod_vld_r, err_out_r;

  logic [mme_pkg::ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;

  function automatic logic [mme_pkg::ADDR_W-1:0] elem_addr(
    input logic [mme_pkg::DIM_W-1:0] r,
    input logic [mme_pkg::DIM_W-1:0] c
  );
    return mme_pkg::ADDR_W'(32'(r) * mme_pkg::MAX_DIM + 32'(c));
  endfunction

  assign wr_addr   = elem_addr(mme_pkg::DIM_W'(in_row), mme_pkg::DIM_W'(in_col));
  assign a_rd_addr = elem_addr(row_r, cmd.k);
  assign b_rd_addr = elem_addr(cmd.k, col_r);

  always_ff @(posedge clk) begin
    if (cmd.a_we) begin
      a_mem[wr_addr] <= in_value;
    end
    if (cmd.b_we) begin
      b_mem[wr_addr] <= in_value;
    end
    a_q_r <= a_mem[a_rd_addr];
    b_q_r <= b_mem[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= mme_pkg::DIM_W'(in_row);
      col_r <= mme_pkg::DIM_W'(in_col);
    end
    prod_r <= a_q_r * b_q_r;
    if (cmd.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + mme_pkg::SUM_W'(prod_r);
    end
    if (cmd.finish) begin
      sum_r     <= cmd.err ? '0 : acc_r;
      err_out_r <= cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  assign sts.busy        = rd_vld_r || prod_vld_r;
  assign out_sum         = sum_r;
  assign out_index_error = err_out_r;

endmodule
`default_nettype wire

// ===== sv/matrix_multiply_engine_unit.sv =====
`default_nettype none
// Channel   Dir  Payload                              Beat taken when
// in_ch     in   mode[1:0] row[3:0] col[3:0] value    valid && ready
// out_ch    out  sum[39:0] index_error                valid && ready
// cfg_*     in   cfg_index[1:0] cfg_data[4:0]         cfg_we
//
// Load beats are accepted back to back. A fetch holds in_ch off until its
// result is loaded into the result register; the single multiply-accumulate
// walks the dot product one term per cycle off the two store read ports.
// An out-of-range fetch or inner_n of zero skips the walk.
// Synchronous active-low reset clears control state and the size registers
// (16 each); the element stores are not cleared and must be loaded first.
// A held result does not block loads; a finished fetch waits for out_ch.
module matrix_multiply_engine_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [mme_pkg::CFG_A_W-1:0]    cfg_index,
  input  wire [mme_pkg::CFG_W-1:0]      cfg_data,
  mme_in_if.sink                        in_ch,
  mme_out_if.source                     out_ch
);

  mme_pkg::mme_cmd_t cmd;  // controller commands
  mme_pkg::mme_sts_t sts;  // datapath status

  // Sequencer: size registers, range checks, dot-product counter,
  // result handshake.
  mme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Element stores, registered read, product register, 40-bit accumulator
  // and the result register.
  mme_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_row          (in_ch.row),
    .in_col          (in_ch.col),
    .in_value        (in_ch.value),
    .out_sum         (out_ch.sum),
    .out_index_error (out_ch.index_error),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire
